>>> hdl/htw_pkg.sv
// Package for the hierarchical timer wheel: sizes, codes, command and timing types.
// Used by every module of the block; depends on nothing.
`default_nettype none
package htw_pkg;

    localparam int TIMERS       = 64;
    localparam int DAY_SLOTS    = 30;
    localparam int SECOND_SLOTS = 60;
    localparam int MINUTE_SLOTS = 60;
    localparam int HOUR_SLOTS   = 24;
    localparam int MAX_RESULTS  = 64;
    localparam int MIN_BASE     = SECOND_SLOTS;
    localparam int HOUR_BASE    = MIN_BASE + MINUTE_SLOTS;
    localparam int DAY_BASE     = HOUR_BASE + HOUR_SLOTS;
    localparam int NSLOTS       = DAY_BASE + DAY_SLOTS;
    localparam int SECS_PER_DAY = 86400;
    localparam int MAX_DELAY    = DAY_SLOTS * SECS_PER_DAY - 1;

    localparam int EW  = $clog2(TIMERS + 1);      // entry index incl. nil
    localparam int AW  = $clog2(TIMERS);          // pool address
    localparam int SW  = $clog2(NSLOTS);          // slot index
    localparam int CW  = $clog2(MAX_RESULTS + 1); // result count
    localparam int NIL = TIMERS;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ADD  = 2'd1,
        OP_DEL  = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_EXPIRED   = 3'd1;
    localparam logic [2:0] ST_DELETED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_NO_EXP    = 3'd5;

    typedef struct packed {
        opcode_t     op;
        logic [21:0] delay;
        logic        rep;
        logic [15:0] target;
    } cmd_t;

    typedef struct packed {
        logic [21:0] delay;
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic        rep;
    } timing_t;

    typedef enum logic [4:0] {
        S_IDLE, S_A_SCAN, S_A_DONE, S_D_RD, S_D_CHK, S_EMIT,
        S_T_ADV, S_T_STAGE, S_C_RD, S_C_H, S_C_E, S_C_E2, S_C_NXT,
        S_X_RD, S_X_H, S_X_E, S_X_E2, S_X_EMIT, S_X_NXT,
        S_P_INIT, S_P_DIG, S_P_FIN, S_L_RD, S_L_H, S_L_H2, S_L_H3
    } back_state_t;

    // Weight tried at each restoring step: days, then hours, then minutes, MSB first.
    function automatic logic [21:0] dig_weight(input logic [3:0] step);
        logic [21:0] w;
        case (step)
            4'd0:    w = 22'(SECS_PER_DAY * 16);
            4'd1:    w = 22'(SECS_PER_DAY * 8);
            4'd2:    w = 22'(SECS_PER_DAY * 4);
            4'd3:    w = 22'(SECS_PER_DAY * 2);
            4'd4:    w = 22'(SECS_PER_DAY);
            4'd5:    w = 22'(3600 * 16);
            4'd6:    w = 22'(3600 * 8);
            4'd7:    w = 22'(3600 * 4);
            4'd8:    w = 22'(3600 * 2);
            4'd9:    w = 22'(3600);
            4'd10:   w = 22'(60 * 32);
            4'd11:   w = 22'(60 * 16);
            4'd12:   w = 22'(60 * 8);
            4'd13:   w = 22'(60 * 4);
            4'd14:   w = 22'(60 * 2);
            default: w = 22'(60);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

>>> hdl/hierarchical_timer_wheel_top.sv
// Top level of the hierarchical timer wheel: command front end feeding the
// wheel sequencer through a four-entry queue. Depends on htw_pkg, htw_front, htw_back.
//
// Four-ring timing wheel (seconds, minutes, hours, days) over a 64-entry timer pool.
// Commands enter on the s_ channel (opcode in s_tuser) and are queued up to four deep;
// results leave on the m_ channel through an output register, status in m_tuser,
// id in m_tdata and m_tlast on the final result of a command. Commands run one at a
// time in a sequencer over memories with one write and one registered read port each.
// Add scans the pool for a free entry, then splits the expiry into digits (16
// restoring steps) and links the timer. Delete scans the pool entries by id. Tick
// advances the rings, cascades the wrapped slots, moves their timers, expires the
// timers of the second slot and re-arms repeat timers; output stalls can hold each
// command. Slot heads clear at reset through per-slot valid bits, so no clearing
// pass is needed.
`default_nettype none
module hierarchical_timer_wheel_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // delay_seconds[21:0], repeat_req[22], target_id[38:23]
    input  wire logic [1:0]  s_tuser,  // opcode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,  // tmr_id[15:0]
    output logic [2:0]       m_tuser,  // status[2:0]
    output logic             m_tlast
);
    import htw_pkg::*;

    cmd_t q_data;
    logic q_valid;
    logic q_pop;

    htw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_data   (q_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop)
    );

    htw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_data   (q_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

>>> hdl/htw_front.sv
// Front end: takes input transfers, decodes the opcode, normalizes the delay
// and queues commands for the back end. Depends on htw_pkg.
`default_nettype none
module htw_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [39:0]   s_tdata,  // delay_seconds[21:0], repeat_req[22], target_id[38:23]
    input  wire logic [1:0]    s_tuser,  // opcode[1:0]
    output htw_pkg::cmd_t      q_data,
    output logic               q_valid,
    input  wire logic          q_pop
);
    import htw_pkg::*;

    cmd_t           q_mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;
    cmd_t           cmd_in;
    logic           push;
    logic [21:0]    d_raw;

    assign s_tready = (count_reg != (QAW+1)'(QDEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_data   = q_mem[rd_ptr_reg];

    always_comb begin
        d_raw         = s_tdata[21:0];
        cmd_in.op     = opcode_t'(s_tuser);
        cmd_in.rep    = s_tdata[22];
        cmd_in.target = s_tdata[38:23];
        if (d_raw == 22'd0) begin
            cmd_in.delay = 22'd1;
        end else if (d_raw > 22'(MAX_DELAY)) begin
            cmd_in.delay = 22'(MAX_DELAY);
        end else begin
            cmd_in.delay = d_raw;
        end
        // unused opcode has no effect: it is taken and dropped here
        push        = s_tvalid && s_tready && (cmd_in.op != OP_NONE);
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QAW+1)'(push) - (QAW+1)'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule
`default_nettype wire

>>> hdl/htw_back.sv
// Back end: sequencer that owns the slot heads, the timer pool memories and the
// ring positions, and runs add, delete and tick commands. Depends on htw_pkg.
`default_nettype none
module htw_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire htw_pkg::cmd_t q_data,
    input  wire logic          q_valid,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [15:0]        m_tdata,  // tmr_id[15:0]
    output logic [2:0]         m_tuser,  // status[2:0]
    output logic               m_tlast
);
    import htw_pkg::*;

    // memories
    logic [EW-1:0] head_mem [NSLOTS];
    logic [EW-1:0] next_mem [TIMERS];
    logic [EW-1:0] prev_mem [TIMERS];
    logic [SW-1:0] slot_mem [TIMERS];
    timing_t       tim_mem  [TIMERS];
    logic [15:0]   id_mem   [TIMERS];

    logic [NSLOTS-1:0] head_vld_reg;
    logic [EW-1:0]     head_rd;
    logic              head_vrd;
    logic [EW-1:0]     next_rd, prev_rd;
    logic [SW-1:0]     slot_rd;
    timing_t           tim_rd;
    logic [15:0]       id_rd;

    logic [SW-1:0] head_ra, head_wa;
    logic [EW-1:0] head_wd;
    logic          head_we;
    logic [AW-1:0] ent_ra;
    logic          next_we, prev_we, slot_we, tim_we, id_we;
    logic [AW-1:0] next_wa, prev_wa, slot_wa, tim_wa, id_wa;
    logic [EW-1:0] next_wd, prev_wd;
    logic [SW-1:0] slot_wd;
    timing_t       tim_wd;
    logic [15:0]   id_wd;

    back_state_t state_reg, state_next;
    back_state_t place_ret_reg, place_ret_next;
    back_state_t link_ret_reg, link_ret_next;
    logic [1:0]  stage_reg, stage_next;
    logic [AW-1:0] idx_reg, idx_next;
    cmd_t        cmd_reg, cmd_next;
    logic [EW-1:0] cur_e_reg, cur_e_next, cur_nx_reg, cur_nx_next;
    logic [EW-1:0] link_e_reg, link_e_next, link_h_reg, link_h_next;
    logic [EW-1:0] link_hn_reg, link_hn_next;
    logic [SW-1:0] link_slot_reg, link_slot_next, csrc_reg, csrc_next;
    logic [21:0] p_delay_reg, p_delay_next, rem_reg, rem_next;
    logic        p_rep_reg, p_rep_next;
    logic [3:0]  step_reg, step_next;
    logic [4:0]  ahead_reg, ahead_next, hour_d_reg, hour_d_next;
    logic [5:0]  min_d_reg, min_d_next;
    logic [5:0]  pos_sec_reg, pos_sec_next, pos_min_reg, pos_min_next;
    logic [4:0]  pos_hour_reg, pos_hour_next, pos_day_reg, pos_day_next;
    logic        wrap_min_reg, wrap_min_next, wrap_hour_reg, wrap_hour_next;
    logic        wrap_day_reg, wrap_day_next;
    logic [15:0] id_cnt_reg, id_cnt_next, cur_id_reg, cur_id_next;
    logic [CW-1:0] n_reg, n_next;
    logic [TIMERS-1:0] free_reg, free_next;
    logic [2:0]  res_status_reg, res_status_next;
    logic [15:0] res_id_reg, res_id_next;
    logic        m_valid_reg, m_valid_next;
    logic [2:0]  m_status_reg, m_status_next;
    logic [15:0] m_id_reg, m_id_next;
    logic        m_last_reg, m_last_next;

    logic          out_free;
    logic          emit;
    logic [2:0]    emit_status;
    logic [15:0]   emit_id;
    logic          emit_last;
    logic [EW-1:0] head_eff;
    logic [21:0]   now_sec, dw;
    logic          ge;
    logic [5:0]    day_sum;
    logic [4:0]    day_v;
    logic [15:0]   id_inc;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_id_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign out_free = !m_valid_reg || m_tready;
    assign head_eff = head_vrd ? head_rd : EW'(NIL);

    always_comb begin
        state_next      = state_reg;
        place_ret_next  = place_ret_reg;
        link_ret_next   = link_ret_reg;
        stage_next      = stage_reg;
        idx_next        = idx_reg;
        cmd_next        = cmd_reg;
        cur_e_next      = cur_e_reg;
        cur_nx_next     = cur_nx_reg;
        link_e_next     = link_e_reg;
        link_h_next     = link_h_reg;
        link_hn_next    = link_hn_reg;
        link_slot_next  = link_slot_reg;
        csrc_next       = csrc_reg;
        p_delay_next    = p_delay_reg;
        p_rep_next      = p_rep_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        ahead_next      = ahead_reg;
        hour_d_next     = hour_d_reg;
        min_d_next      = min_d_reg;
        pos_sec_next    = pos_sec_reg;
        pos_min_next    = pos_min_reg;
        pos_hour_next   = pos_hour_reg;
        pos_day_next    = pos_day_reg;
        wrap_min_next   = wrap_min_reg;
        wrap_hour_next  = wrap_hour_reg;
        wrap_day_next   = wrap_day_reg;
        id_cnt_next     = id_cnt_reg;
        cur_id_next     = cur_id_reg;
        n_next          = n_reg;
        free_next       = free_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;

        q_pop       = 1'b0;
        emit        = 1'b0;
        emit_status = ST_NO_EXP;
        emit_id     = 16'd0;
        emit_last   = 1'b1;

        head_ra = link_slot_reg;
        head_we = 1'b0;
        head_wa = link_slot_reg;
        head_wd = EW'(NIL);
        ent_ra  = cur_e_reg[AW-1:0];
        next_we = 1'b0; next_wa = link_e_reg[AW-1:0]; next_wd = EW'(NIL);
        prev_we = 1'b0; prev_wa = link_e_reg[AW-1:0]; prev_wd = EW'(NIL);
        slot_we = 1'b0; slot_wa = link_e_reg[AW-1:0]; slot_wd = link_slot_reg;
        tim_we  = 1'b0; tim_wa  = cur_e_reg[AW-1:0];
        id_we   = 1'b0; id_wa   = idx_reg;

        now_sec = 22'(pos_hour_reg) * 22'd3600 + 22'(pos_min_reg) * 22'd60
                + 22'(pos_sec_reg);
        dw      = dig_weight(step_reg);
        ge      = (rem_reg >= dw);
        day_sum = 6'(pos_day_reg) + 6'(ahead_reg);
        day_v   = (day_sum >= 6'(DAY_SLOTS)) ? 5'(day_sum - 6'(DAY_SLOTS)) : day_sum[4:0];
        id_inc  = (id_cnt_reg == 16'hFFFF) ? 16'd1 : id_cnt_reg + 16'd1;
        tim_wd.delay = p_delay_reg;
        tim_wd.sec   = rem_reg[5:0];
        tim_wd.min   = min_d_reg;
        tim_wd.hour  = hour_d_reg;
        tim_wd.day   = day_v;
        tim_wd.rep   = p_rep_reg;
        id_wd        = id_inc;

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                    idx_next = '0;
                    case (q_data.op)
                        OP_ADD:  state_next = S_A_SCAN;
                        OP_DEL:  state_next = S_D_RD;
                        OP_TICK: state_next = S_T_ADV;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_A_SCAN: begin
                if (free_reg[idx_reg]) begin
                    cur_e_next         = EW'(idx_reg);
                    id_cnt_next        = id_inc;
                    free_next[idx_reg] = 1'b0;
                    id_we              = 1'b1;
                    p_delay_next       = cmd_reg.delay;
                    p_rep_next         = cmd_reg.rep;
                    place_ret_next     = S_A_DONE;
                    state_next         = S_P_INIT;
                end else if (idx_reg == AW'(TIMERS - 1)) begin
                    res_status_next = ST_FULL;
                    res_id_next     = 16'd0;
                    state_next      = S_EMIT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_A_DONE: begin
                if (out_free) begin
                    emit        = 1'b1;
                    emit_status = ST_ADDED;
                    emit_id     = id_cnt_reg;
                    state_next  = S_IDLE;
                end
            end
            S_D_RD: begin
                ent_ra     = idx_reg;
                state_next = S_D_CHK;
            end
            S_D_CHK: begin
                if (!free_reg[idx_reg] && id_rd == cmd_reg.target && cmd_reg.target != 16'd0) begin
                    // unlink with the links read along with the id
                    if (prev_rd != EW'(NIL)) begin
                        next_we = 1'b1;
                        next_wa = prev_rd[AW-1:0];
                        next_wd = next_rd;
                    end else begin
                        head_we = 1'b1;
                        head_wa = slot_rd;
                        head_wd = next_rd;
                    end
                    if (next_rd != EW'(NIL)) begin
                        prev_we = 1'b1;
                        prev_wa = next_rd[AW-1:0];
                        prev_wd = prev_rd;
                    end
                    free_next[idx_reg] = 1'b1;
                    res_status_next    = ST_DELETED;
                    res_id_next        = cmd_reg.target;
                    state_next         = S_EMIT;
                end else if (idx_reg == AW'(TIMERS - 1)) begin
                    res_status_next = ST_NOT_FOUND;
                    res_id_next     = 16'd0;
                    state_next      = S_EMIT;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_D_RD;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    emit        = 1'b1;
                    emit_status = res_status_reg;
                    emit_id     = res_id_reg;
                    state_next  = S_IDLE;
                end
            end
            S_T_ADV: begin
                wrap_min_next  = 1'b0;
                wrap_hour_next = 1'b0;
                wrap_day_next  = 1'b0;
                if (pos_sec_reg == 6'(SECOND_SLOTS - 1)) begin
                    pos_sec_next  = '0;
                    wrap_min_next = 1'b1;
                    if (pos_min_reg == 6'(MINUTE_SLOTS - 1)) begin
                        pos_min_next   = '0;
                        wrap_hour_next = 1'b1;
                        if (pos_hour_reg == 5'(HOUR_SLOTS - 1)) begin
                            pos_hour_next = '0;
                            wrap_day_next = 1'b1;
                            pos_day_next  = (pos_day_reg == 5'(DAY_SLOTS - 1)) ? 5'd0
                                          : pos_day_reg + 5'd1;
                        end else begin
                            pos_hour_next = pos_hour_reg + 5'd1;
                        end
                    end else begin
                        pos_min_next = pos_min_reg + 6'd1;
                    end
                end else begin
                    pos_sec_next = pos_sec_reg + 6'd1;
                end
                stage_next = 2'd0;
                state_next = S_T_STAGE;
            end
            S_T_STAGE: begin
                // day, hour, minute cascades in that order, then the second slot
                case (stage_reg)
                    2'd0: begin
                        csrc_next  = SW'(DAY_BASE) + SW'(pos_day_reg);
                        state_next = wrap_day_reg ? S_C_RD : S_T_STAGE;
                    end
                    2'd1: begin
                        csrc_next  = SW'(HOUR_BASE) + SW'(pos_hour_reg);
                        state_next = wrap_hour_reg ? S_C_RD : S_T_STAGE;
                    end
                    2'd2: begin
                        csrc_next  = SW'(MIN_BASE) + SW'(pos_min_reg);
                        state_next = wrap_min_reg ? S_C_RD : S_T_STAGE;
                    end
                    default: state_next = S_X_RD;
                endcase
                if (state_next == S_T_STAGE) begin
                    stage_next = stage_reg + 2'd1;
                end
            end
            S_C_RD: begin
                head_ra    = csrc_reg;
                state_next = S_C_H;
            end
            S_C_H: begin
                head_we = 1'b1;
                head_wa = csrc_reg;
                head_wd = EW'(NIL);
                if (head_eff == EW'(NIL)) begin
                    stage_next = stage_reg + 2'd1;
                    state_next = S_T_STAGE;
                end else begin
                    cur_e_next = head_eff;
                    state_next = S_C_E;
                end
            end
            S_C_E: begin
                state_next = S_C_E2;
            end
            S_C_E2: begin
                cur_nx_next   = next_rd;
                link_e_next   = cur_e_reg;
                link_ret_next = S_C_NXT;
                case (stage_reg)
                    2'd0:    link_slot_next = SW'(HOUR_BASE) + SW'(tim_rd.hour);
                    2'd1:    link_slot_next = SW'(MIN_BASE) + SW'(tim_rd.min);
                    default: link_slot_next = SW'(tim_rd.sec);
                endcase
                state_next = S_L_RD;
            end
            S_C_NXT: begin
                if (cur_nx_reg == EW'(NIL)) begin
                    stage_next = stage_reg + 2'd1;
                    state_next = S_T_STAGE;
                end else begin
                    cur_e_next = cur_nx_reg;
                    state_next = S_C_E;
                end
            end
            S_X_RD: begin
                head_ra    = SW'(pos_sec_reg);
                state_next = S_X_H;
            end
            S_X_H: begin
                head_we = 1'b1;
                head_wa = SW'(pos_sec_reg);
                head_wd = EW'(NIL);
                n_next  = '0;
                if (head_eff == EW'(NIL)) begin
                    res_status_next = ST_NO_EXP;
                    res_id_next     = 16'd0;
                    state_next      = S_EMIT;
                end else begin
                    cur_e_next = head_eff;
                    state_next = S_X_E;
                end
            end
            S_X_E: begin
                state_next = S_X_E2;
            end
            S_X_E2: begin
                cur_nx_next  = next_rd;
                cur_id_next  = id_rd;
                p_delay_next = tim_rd.delay;
                p_rep_next   = tim_rd.rep;
                state_next   = S_X_EMIT;
            end
            S_X_EMIT: begin
                if (n_reg < CW'(MAX_RESULTS) && !out_free) begin
                    state_next = S_X_EMIT;
                end else begin
                    if (n_reg < CW'(MAX_RESULTS)) begin
                        emit        = 1'b1;
                        emit_status = ST_EXPIRED;
                        emit_id     = cur_id_reg;
                        emit_last   = (cur_nx_reg == EW'(NIL)) || (n_reg == CW'(MAX_RESULTS - 1));
                        n_next      = n_reg + 1'b1;
                    end
                    if (p_rep_reg) begin
                        place_ret_next = S_X_NXT;
                        state_next     = S_P_INIT;
                    end else begin
                        free_next[cur_e_reg[AW-1:0]] = 1'b1;
                        state_next = S_X_NXT;
                    end
                end
            end
            S_X_NXT: begin
                if (cur_nx_reg == EW'(NIL)) begin
                    state_next = S_IDLE;
                end else begin
                    cur_e_next = cur_nx_reg;
                    state_next = S_X_E;
                end
            end
            S_P_INIT: begin
                rem_next    = now_sec + p_delay_reg;
                step_next   = 4'd0;
                ahead_next  = '0;
                hour_d_next = '0;
                min_d_next  = '0;
                state_next  = S_P_DIG;
            end
            S_P_DIG: begin
                if (ge) begin
                    rem_next = rem_reg - dw;
                end
                if (step_reg <= 4'd4) begin
                    ahead_next = {ahead_reg[3:0], ge};
                end else if (step_reg <= 4'd9) begin
                    hour_d_next = {hour_d_reg[3:0], ge};
                end else begin
                    min_d_next = {min_d_reg[4:0], ge};
                end
                step_next  = step_reg + 4'd1;
                state_next = (step_reg == 4'd15) ? S_P_FIN : S_P_DIG;
            end
            S_P_FIN: begin
                tim_we        = 1'b1;
                link_e_next   = cur_e_reg;
                link_ret_next = place_ret_reg;
                if (ahead_reg != 5'd0) begin
                    link_slot_next = SW'(DAY_BASE) + SW'(day_v);
                end else if (hour_d_reg != pos_hour_reg) begin
                    link_slot_next = SW'(HOUR_BASE) + SW'(hour_d_reg);
                end else if (min_d_reg != pos_min_reg) begin
                    link_slot_next = SW'(MIN_BASE) + SW'(min_d_reg);
                end else begin
                    link_slot_next = SW'(rem_reg[5:0]);
                end
                state_next = S_L_RD;
            end
            S_L_RD: begin
                head_ra    = link_slot_reg;
                state_next = S_L_H;
            end
            S_L_H: begin
                slot_we = 1'b1;
                if (head_eff == EW'(NIL)) begin
                    head_we    = 1'b1;
                    head_wa    = link_slot_reg;
                    head_wd    = link_e_reg;
                    next_we    = 1'b1;
                    prev_we    = 1'b1;
                    state_next = link_ret_reg;
                end else begin
                    link_h_next = head_eff;
                    ent_ra      = head_eff[AW-1:0];
                    state_next  = S_L_H2;
                end
            end
            S_L_H2: begin
                // new entry goes right after the head
                link_hn_next = next_rd;
                next_we      = 1'b1;
                next_wd      = next_rd;
                prev_we      = 1'b1;
                prev_wd      = link_h_reg;
                state_next   = S_L_H3;
            end
            S_L_H3: begin
                next_we = 1'b1;
                next_wa = link_h_reg[AW-1:0];
                next_wd = link_e_reg;
                if (link_hn_reg != EW'(NIL)) begin
                    prev_we = 1'b1;
                    prev_wa = link_hn_reg[AW-1:0];
                    prev_wd = link_e_reg;
                end
                state_next = link_ret_reg;
            end
            default: state_next = S_IDLE;
        endcase

        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_id_next     = m_id_reg;
        m_last_next   = m_last_reg;
        if (emit) begin
            m_valid_next  = 1'b1;
            m_status_next = emit_status;
            m_id_next     = emit_id;
            m_last_next   = emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            place_ret_reg <= S_IDLE;
            link_ret_reg  <= S_IDLE;
            stage_reg     <= '0;
            pos_sec_reg   <= '0;
            pos_min_reg   <= '0;
            pos_hour_reg  <= '0;
            pos_day_reg   <= '0;
            id_cnt_reg    <= '0;
            free_reg      <= '1;
            head_vld_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            place_ret_reg <= place_ret_next;
            link_ret_reg  <= link_ret_next;
            stage_reg     <= stage_next;
            pos_sec_reg   <= pos_sec_next;
            pos_min_reg   <= pos_min_next;
            pos_hour_reg  <= pos_hour_next;
            pos_day_reg   <= pos_day_next;
            id_cnt_reg    <= id_cnt_next;
            free_reg      <= free_next;
            m_valid_reg   <= m_valid_next;
            if (head_we) begin
                head_vld_reg[head_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        cmd_reg        <= cmd_next;
        cur_e_reg      <= cur_e_next;
        cur_nx_reg     <= cur_nx_next;
        link_e_reg     <= link_e_next;
        link_h_reg     <= link_h_next;
        link_hn_reg    <= link_hn_next;
        link_slot_reg  <= link_slot_next;
        csrc_reg       <= csrc_next;
        p_delay_reg    <= p_delay_next;
        p_rep_reg      <= p_rep_next;
        rem_reg        <= rem_next;
        step_reg       <= step_next;
        ahead_reg      <= ahead_next;
        hour_d_reg     <= hour_d_next;
        min_d_reg      <= min_d_next;
        wrap_min_reg   <= wrap_min_next;
        wrap_hour_reg  <= wrap_hour_next;
        wrap_day_reg   <= wrap_day_next;
        cur_id_reg     <= cur_id_next;
        n_reg          <= n_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        m_status_reg   <= m_status_next;
        m_id_reg       <= m_id_next;
        m_last_reg     <= m_last_next;
    end

    // memory ports: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (head_we) head_mem[head_wa] <= head_wd;
        head_rd  <= head_mem[head_ra];
        head_vrd <= head_vld_reg[head_ra];
    end

    always_ff @(posedge aclk) begin
        if (next_we) next_mem[next_wa] <= next_wd;
        if (prev_we) prev_mem[prev_wa] <= prev_wd;
        if (slot_we) slot_mem[slot_wa] <= slot_wd;
        if (tim_we)  tim_mem[tim_wa]   <= tim_wd;
        if (id_we)   id_mem[id_wa]     <= id_wd;
        next_rd <= next_mem[ent_ra];
        prev_rd <= prev_mem[ent_ra];
        slot_rd <= slot_mem[ent_ra];
        tim_rd  <= tim_mem[ent_ra];
        id_rd   <= id_mem[ent_ra];
    end

endmodule
`default_nettype wire

>>> hdl/htw_checker.sv
// Port-level checks for the hierarchical timer wheel, bound to the top level.
// Depends on htw_pkg and hierarchical_timer_wheel_top.
`default_nettype none
module htw_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [39:0] s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);
    import htw_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input transfer changed while waiting");

    a_noid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_NOT_FOUND || m_tuser == ST_FULL || m_tuser == ST_NO_EXP)
        |-> m_tdata == 16'd0 && m_tlast)
        else $error("id-less result carries an id or is not last");

    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_ADDED || m_tuser == ST_DELETED)
        |-> m_tlast && m_tdata != 16'd0)
        else $error("add or delete result malformed");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= ST_NO_EXP)
        else $error("status code out of range");

endmodule

bind hierarchical_timer_wheel_top htw_checker u_htw_checker (.*);
`default_nettype wire

>>> tb/testbench.sv
// Testbench for the hierarchical timer wheel: directed and random add, delete and
// tick commands, each result checked against an in-bench model. Depends on htw_pkg and hierarchical_timer_wheel_top.
`default_nettype none
module testbench;
    import htw_pkg::*;

    localparam int NONE = TIMERS;

    typedef struct {
        logic [2:0]  status;
        logic [15:0] id;
        logic        last;
    } wheel_result_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = OP_NONE;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    hierarchical_timer_wheel_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // model state
    int          head_of[NSLOTS];
    int          nxt[TIMERS], prv[TIMERS], slot_of[TIMERS];
    timing_t     tm[TIMERS];
    logic [15:0] ids[TIMERS];
    bit          is_free[TIMERS];
    int          cur_sec, cur_min, cur_hour, cur_day;
    logic [15:0] id_count;

    wheel_result_t pending_results[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic [15:0] recent_ids[$];

    initial forever #4 aclk = ~aclk;

    function automatic void wheel_reset();
        for (int i = 0; i < NSLOTS; i++) head_of[i] = NONE;
        for (int i = 0; i < TIMERS; i++) begin
            is_free[i] = 1; nxt[i] = NONE; prv[i] = NONE; slot_of[i] = 0; ids[i] = 0;
            tm[i] = '0;
        end
        cur_sec = 0; cur_min = 0; cur_hour = 0; cur_day = 0; id_count = 0;
    endfunction

    function automatic void link_entry(int s, int e);
        int h;
        h = head_of[s];
        slot_of[e] = s;
        if (h == NONE) begin
            head_of[s] = e; nxt[e] = NONE; prv[e] = NONE;
        end else begin
            nxt[e] = nxt[h]; prv[e] = h; nxt[h] = e;
            if (nxt[e] != NONE) prv[nxt[e]] = e;
        end
    endfunction

    function automatic void arm_timer(int e);
        int now, ex, ahead, rem;
        now = cur_hour * 3600 + cur_min * 60 + cur_sec;
        ex = now + int'(tm[e].delay);
        ahead = ex / SECS_PER_DAY;
        rem = ex % SECS_PER_DAY;
        tm[e].hour = 5'(rem / 3600);
        tm[e].min = 6'((rem / 60) % 60);
        tm[e].sec = 6'(rem % 60);
        tm[e].day = 5'((cur_day + ahead) % DAY_SLOTS);
        if (ahead > 0) link_entry(DAY_BASE + tm[e].day, e);
        else if (tm[e].hour != cur_hour) link_entry(HOUR_BASE + tm[e].hour, e);
        else if (tm[e].min != cur_min) link_entry(MIN_BASE + tm[e].min, e);
        else link_entry(tm[e].sec, e);
    endfunction

    function automatic void cascade_slot(int src, int level);
        int e, nx, dst;
        e = head_of[src];
        head_of[src] = NONE;
        while (e != NONE) begin
            nx = nxt[e];
            if (level == 0) dst = tm[e].sec;
            else if (level == 1) dst = MIN_BASE + tm[e].min;
            else dst = HOUR_BASE + tm[e].hour;
            link_entry(dst, e);
            e = nx;
        end
    endfunction

    function automatic void push_result(logic [2:0] st, logic [15:0] id, logic lst);
        wheel_result_t r;
        r.status = st; r.id = id; r.last = lst;
        pending_results = {pending_results, r};
    endfunction

    // Predicts the results of one command and appends them to pending_results.
    function automatic void predict_wheel(opcode_t op, logic [21:0] dly, logic rep,
                                          logic [15:0] tgt);
        int e, nx, n;
        bit wm, wh, wd;
        e = NONE; n = 0; wm = 0; wh = 0; wd = 0;
        case (op)
            OP_ADD: begin
                for (int i = TIMERS - 1; i >= 0; i--) if (is_free[i]) e = i;
                if (e == NONE) push_result(ST_FULL, 16'd0, 1'b1);
                else begin
                    id_count = id_count + 16'd1;
                    if (id_count == 0) id_count = 1;
                    if (dly == 0) dly = 1;
                    if (dly > MAX_DELAY) dly = 22'(MAX_DELAY);
                    is_free[e] = 0; ids[e] = id_count;
                    tm[e].delay = dly; tm[e].rep = rep;
                    arm_timer(e);
                    recent_ids = {recent_ids, id_count};
                    push_result(ST_ADDED, id_count, 1'b1);
                end
            end
            OP_DEL: begin
                for (int i = TIMERS - 1; i >= 0; i--)
                    if (!is_free[i] && ids[i] == tgt && tgt != 0) e = i;
                if (e == NONE) push_result(ST_NOT_FOUND, 16'd0, 1'b1);
                else begin
                    if (prv[e] != NONE) nxt[prv[e]] = nxt[e];
                    else head_of[slot_of[e]] = nxt[e];
                    if (nxt[e] != NONE) prv[nxt[e]] = prv[e];
                    is_free[e] = 1;
                    push_result(ST_DELETED, tgt, 1'b1);
                end
            end
            OP_TICK: begin
                cur_sec++;
                if (cur_sec >= SECOND_SLOTS) begin
                    cur_sec = 0; wm = 1; cur_min++;
                    if (cur_min >= MINUTE_SLOTS) begin
                        cur_min = 0; wh = 1; cur_hour++;
                        if (cur_hour >= HOUR_SLOTS) begin
                            cur_hour = 0; wd = 1; cur_day = (cur_day + 1) % DAY_SLOTS;
                        end
                    end
                end
                if (wd) cascade_slot(DAY_BASE + cur_day, 2);
                if (wh) cascade_slot(HOUR_BASE + cur_hour, 1);
                if (wm) cascade_slot(MIN_BASE + cur_min, 0);
                e = head_of[cur_sec];
                head_of[cur_sec] = NONE;
                while (e != NONE) begin
                    nx = nxt[e];
                    if (n < MAX_RESULTS) begin
                        push_result(ST_EXPIRED, ids[e], 1'b0);
                        n++;
                    end
                    if (tm[e].rep) arm_timer(e);
                    else is_free[e] = 1;
                    e = nx;
                end
                if (n == 0) push_result(ST_NO_EXP, 16'd0, 1'b1);
                else pending_results[$].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // Leaves tvalid high after the transfer; the next call or drain() changes it.
    task automatic send_command(opcode_t op, logic [21:0] dly, logic rep, logic [15:0] tgt);
        while (($urandom % 100) < send_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {1'b0, tgt, rep, dly};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_wheel(op, dly, rep, tgt);
        @(negedge aclk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 0;
        while (pending_results.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (300) @(negedge aclk);
    endtask

    task automatic tick_n(int n);
        for (int i = 0; i < n; i++) send_command(OP_TICK, 0, 0, 0);
    endtask

    // receiver stall pattern
    always @(negedge aclk) m_tready <= (($urandom % 100) >= recv_idle_pct);

    always @(posedge aclk) begin
        wheel_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: status %0d id %0d last %0b",
                             m_tuser, m_tdata, m_tlast);
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tuser !== exp_r.status || m_tdata !== exp_r.id ||
                    m_tlast !== exp_r.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp status %0d id %0d last %0b, got %0d %0d %0b",
                                 exp_r.status, exp_r.id, exp_r.last, m_tuser, m_tdata, m_tlast);
                end
            end
        end
    end

    task automatic test_directed();
        send_command(OP_TICK, 0, 0, 0);            // tick, nothing armed
        send_command(OP_ADD, 0, 0, 0);             // zero delay acts as one
        send_command(OP_ADD, 22'h3FFFFF, 1, 16'hFFFF); // clamped
        send_command(OP_ADD, 2591999, 0, 0);
        send_command(OP_ADD, 59, 0, 0);
        send_command(OP_ADD, 61, 1, 0);
        send_command(OP_ADD, 3601, 0, 0);
        send_command(OP_ADD, 86400, 0, 0);
        send_command(OP_DEL, 0, 0, 0);             // id zero never matches
        send_command(OP_DEL, 0, 0, 16'hFFFF);      // unknown id
        send_command(OP_DEL, 0, 1, 16'd3);
        send_command(OP_NONE, 22'h3FFFFF, 1, 16'hFFFF); // ignored
        tick_n(3);
        send_command(OP_ADD, 1, 1, 0);
        tick_n(6);
        drain();
    endtask

    task automatic test_pool_full();
        for (int i = 0; i < TIMERS + 2; i++) send_command(OP_ADD, 5, i[0], 0);
        tick_n(6);                                 // many expire in one tick
        drain();
    endtask

    task automatic test_random(int count);
        int k;
        logic [15:0] t;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 99);
            if (k < 45)
                send_command(OP_TICK, 22'($urandom), 1'($urandom), 16'($urandom));
            else if (k < 75)
                send_command(OP_ADD, ($urandom_range(0, 3) == 0) ? 22'($urandom) :
                             22'($urandom_range(0, 200)), 1'($urandom), 16'($urandom));
            else if (k < 95) begin
                t = (recent_ids.size() != 0 && $urandom_range(0, 3) != 0) ?
                    recent_ids[$urandom_range(0, recent_ids.size() - 1)] : 16'($urandom);
                send_command(OP_DEL, 22'($urandom), 1'($urandom), t);
            end else
                send_command(OP_NONE, 22'($urandom), 1'($urandom), 16'($urandom));
        end
        drain();
    endtask

    initial begin
        wheel_reset();
        repeat (7) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        send_idle_pct = 26; recv_idle_pct = 88;
        test_directed();
        test_pool_full();
        test_random(35);
        send_idle_pct = 88; recv_idle_pct = 26;
        test_random(35);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(35);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #40000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

>>> hierarchical_timer_wheel_top.f
hdl/htw_pkg.sv
hdl/htw_front.sv
hdl/htw_back.sv
hdl/hierarchical_timer_wheel_top.sv
hdl/htw_checker.sv
tb/testbench.sv
